FILE: design/udiv_pkg.sv
// udiv_pkg: shared constants and types for the 64-by-32 saturating divider.
// Used by udiv_step and udiv64by32_saturating_unit. No dependencies.
`default_nettype none

package udiv_pkg;

	// Default word width. The dividend is two words, the divisor and quotient one.
	localparam int WORD_BITS_DEF = 32;

	// Fixed port widths.
	localparam int DIVIDEND_BITS = 64;
	localparam int DIVISOR_BITS  = 32;
	localparam int QUOTIENT_BITS = 32;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// Control that travels with each word down the pipeline.
	typedef struct packed {
		logic    valid;
		status_t status;
	} ctl_t;

endpackage : udiv_pkg

`default_nettype wire

FILE: design/udiv_step.sv
// udiv_step: one registered restoring-division step (one quotient bit).
// Depends on udiv_pkg for the control struct.
`default_nettype none

module udiv_step #(
	parameter int WORD_BITS = udiv_pkg::WORD_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  udiv_pkg::ctl_t       in_ctl,
	input  wire [WORD_BITS-1:0]  in_rem,
	input  wire [WORD_BITS-1:0]  in_lq,
	input  wire [WORD_BITS-1:0]  in_dv,
	output udiv_pkg::ctl_t       out_ctl,
	output logic [WORD_BITS-1:0] out_rem,
	output logic [WORD_BITS-1:0] out_lq,
	output logic [WORD_BITS-1:0] out_dv
);

	// lq: untaken dividend bits at the top, quotient bits entering at the bottom.
	logic [WORD_BITS+1:0] diff;
	logic                 borrow;
	logic [WORD_BITS-1:0] rem_nxt;
	logic [WORD_BITS-1:0] lq_nxt;

	always_comb begin
		diff    = {1'b0, in_rem, in_lq[WORD_BITS-1]} - {2'b00, in_dv};
		borrow  = diff[WORD_BITS+1];
		rem_nxt = borrow ? {in_rem[WORD_BITS-2:0], in_lq[WORD_BITS-1]} : diff[WORD_BITS-1:0];
		lq_nxt  = {in_lq[WORD_BITS-2:0], ~borrow};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl.valid  <= 1'b0;
			out_ctl.status <= udiv_pkg::ST_OK;
		end else begin
			out_ctl <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		out_rem <= rem_nxt;
		out_lq  <= lq_nxt;
		out_dv  <= in_dv;
	end

endmodule : udiv_step

`default_nettype wire

FILE: design/udiv64by32_saturating_unit.sv
// udiv64by32_saturating_unit: pipelined unsigned double-word by word divider.
// Depends on udiv_pkg and udiv_step.
`default_nettype none

// Usage
//   Input: drive dividend and divisor and raise start for one cycle per word.
//   A word is taken at every rising edge with start high and busy low. busy
//   is always low: the pipeline takes a new word every cycle.
//   Output: done is high for exactly one cycle with quotient and status; the
//   receiver must take it then, there is no backpressure and none is needed,
//   since every stage moves on each cycle.
//   Pipeline: one input stage that splits the dividend and classifies the
//   word, one stage per quotient bit (each one compare-subtract of
//   WORD_BITS + 1 bits), one output stage.
//   Throughput: one word per cycle; results leave in the order taken.
//   Status: ST_OK, ST_OVF (high word >= divisor, quotient all ones),
//   ST_DIV0 (divisor zero, quotient zero; checked first).
//   Only the low 2*WORD_BITS dividend bits and low WORD_BITS divisor bits
//   are used.
//   Reset: arst_n clears every valid bit at once; words in flight are dropped.
module udiv64by32_saturating_unit #(
	parameter int WORD_BITS = udiv_pkg::WORD_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire [udiv_pkg::DIVIDEND_BITS-1:0]   dividend,
	input  wire [udiv_pkg::DIVISOR_BITS-1:0]    divisor,
	output logic                                done,
	output logic [udiv_pkg::QUOTIENT_BITS-1:0]  quotient,
	output logic [1:0]                          status
);

	// Stage 0 is the input register; stage k holds the word after k steps.
	udiv_pkg::ctl_t       ctl_s [0:WORD_BITS];
	logic [WORD_BITS-1:0] rem_s [0:WORD_BITS];
	logic [WORD_BITS-1:0] lq_s  [0:WORD_BITS];
	logic [WORD_BITS-1:0] dv_s  [0:WORD_BITS];

	logic [WORD_BITS-1:0] hi_in;
	logic [WORD_BITS-1:0] lo_in;
	logic [WORD_BITS-1:0] dv_in;
	udiv_pkg::status_t    st_in;

	logic                 done_q;
	logic [WORD_BITS-1:0] quot_q;
	udiv_pkg::status_t    status_q;
	udiv_pkg::status_t    st_last;

	assign busy = 1'b0;

	// Split the word and classify: zero divisor wins over overflow.
	always_comb begin
		lo_in = dividend[WORD_BITS-1:0];
		hi_in = dividend[2*WORD_BITS-1:WORD_BITS];
		dv_in = divisor[WORD_BITS-1:0];
		if (dv_in == '0) begin
			st_in = udiv_pkg::ST_DIV0;
		end else if (hi_in >= dv_in) begin
			st_in = udiv_pkg::ST_OVF;
		end else begin
			st_in = udiv_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0].valid  <= 1'b0;
			ctl_s[0].status <= udiv_pkg::ST_OK;
		end else begin
			ctl_s[0].valid  <= start & ~busy;
			ctl_s[0].status <= st_in;
		end
	end

	// Partial remainder starts from the high word; the low word is shifted in.
	always_ff @(posedge clk) begin
		rem_s[0] <= hi_in;
		lq_s[0]  <= lo_in;
		dv_s[0]  <= dv_in;
	end

	// One quotient bit per stage, MSB first.
	for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
		udiv_step #(
			.WORD_BITS(WORD_BITS)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.in_ctl (ctl_s[k]),
			.in_rem (rem_s[k]),
			.in_lq  (lq_s[k]),
			.in_dv  (dv_s[k]),
			.out_ctl(ctl_s[k+1]),
			.out_rem(rem_s[k+1]),
			.out_lq (lq_s[k+1]),
			.out_dv (dv_s[k+1])
		);
	end

	// Output stage: the special cases override the computed quotient.
	// The last stage's remainder and divisor are not needed.
	assign st_last = ctl_s[WORD_BITS].status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[WORD_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= st_last;
		case (st_last)
			udiv_pkg::ST_OVF:  quot_q <= '1;
			udiv_pkg::ST_DIV0: quot_q <= '0;
			default:           quot_q <= lq_s[WORD_BITS];
		endcase
	end

	assign done     = done_q;
	assign quotient = udiv_pkg::QUOTIENT_BITS'(quot_q);
	assign status   = status_q;

endmodule : udiv64by32_saturating_unit

`default_nettype wire
